### rtl/npc_pkg.sv
`default_nettype none

package npc_pkg;

   // Field widths
   localparam int COLOR_W = 8;
   localparam int IDX_W   = 8;
   localparam int DIST_W  = 18;

   // Palette geometry
   localparam int ROM_SIZE              = 256;
   localparam int PRIORITY_BASE         = 224;
   localparam int PALETTE_ENTRIES_DEF   = 256;

   typedef logic [COLOR_W-1:0] color_type;
   typedef logic [IDX_W-1:0]   index_type;
   typedef logic [DIST_W-1:0]  dist_type;

   typedef struct packed {
      color_type red;
      color_type green;
      color_type blue;
   } rgb_type;

   // Controller to datapath commands
   typedef struct packed {
      logic      load;     // capture the request color
      logic      issue;    // read one palette entry into the pipeline
      index_type addr;     // palette entry being read
      logic      commit;   // finish the search, update record, fill output
   } npc_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic pipe_busy;     // distance pipeline still holds entries
   } npc_status_type;

   // Fixed palette, red in the top byte
   localparam rgb_type PALETTE_ROM [ROM_SIZE] = '{
      24'h000000, 24'h0F0F0F, 24'h1F1F1F, 24'h2F2F2F,
      24'h3F3F3F, 24'h4B4B4B, 24'h5B5B5B, 24'h6B6B6B,
      24'h7B7B7B, 24'h8B8B8B, 24'h9B9B9B, 24'hABABAB,
      24'hBBBBBB, 24'hCBCBCB, 24'hDBDBDB, 24'hEBEBEB,
      24'h0F0B07, 24'h170F0B, 24'h1F170B, 24'h271B0F,
      24'h2F2313, 24'h372B17, 24'h3F2F17, 24'h4B371B,
      24'h533B1B, 24'h5B431F, 24'h634B1F, 24'h6B531F,
      24'h73571F, 24'h7B5F23, 24'h836723, 24'h8F6F23,
      24'h0B0B0F, 24'h13131B, 24'h1B1B27, 24'h272733,
      24'h2F2F3F, 24'h37374B, 24'h3F3F57, 24'h474767,
      24'h4F4F73, 24'h5B5B7F, 24'h63638B, 24'h6B6B97,
      24'h7373A3, 24'h7B7BAF, 24'h8383BB, 24'h8B8BCB,
      24'h000000, 24'h070700, 24'h0B0B00, 24'h131300,
      24'h1B1B00, 24'h232300, 24'h2B2B07, 24'h2F2F07,
      24'h373707, 24'h3F3F07, 24'h474707, 24'h4B4B0B,
      24'h53530B, 24'h5B5B0B, 24'h63630B, 24'h6B6B0F,
      24'h070000, 24'h0F0000, 24'h170000, 24'h1F0000,
      24'h270000, 24'h2F0000, 24'h370000, 24'h3F0000,
      24'h470000, 24'h4F0000, 24'h570000, 24'h5F0000,
      24'h670000, 24'h6F0000, 24'h770000, 24'h7F0000,
      24'h131300, 24'h1B1B00, 24'h232300, 24'h2F2B00,
      24'h372F00, 24'h433700, 24'h4B3B07, 24'h574307,
      24'h5F4707, 24'h6B4B0B, 24'h77530F, 24'h835713,
      24'h8B5B13, 24'h975F1B, 24'hA3631F, 24'hAF6723,
      24'h231307, 24'h2F170B, 24'h3B1F0F, 24'h4B2313,
      24'h572B17, 24'h632F1F, 24'h733723, 24'h7F3B2B,
      24'h8F4333, 24'h9F4F33, 24'hAF632F, 24'hBF772F,
      24'hCF8F2B, 24'hDFAB27, 24'hEFCB1F, 24'hFFF31B,
      24'h0B0700, 24'h1B1300, 24'h2B230F, 24'h372B13,
      24'h47331B, 24'h533723, 24'h633F2B, 24'h6F4733,
      24'h7F533F, 24'h8B5F47, 24'h9B6B53, 24'hA77B5F,
      24'hB7876B, 24'hC3937B, 24'hD3A38B, 24'hE3B397,
      24'hAB8BA3, 24'h9F7F97, 24'h937387, 24'h8B677B,
      24'h7F5B6F, 24'h775363, 24'h6B4B57, 24'h5F3F4B,
      24'h573743, 24'h4B2F37, 24'h43272F, 24'h371F23,
      24'h2B171B, 24'h231313, 24'h170B0B, 24'h0F0707,
      24'hBB739F, 24'hAF6B8F, 24'hA35F83, 24'h975777,
      24'h8B4F6B, 24'h7F4B5F, 24'h734353, 24'h6B3B4B,
      24'h5F333F, 24'h532B37, 24'h47232B, 24'h3B1F23,
      24'h2F171B, 24'h231313, 24'h170B0B, 24'h0F0707,
      24'hDBC3BB, 24'hCBB3A7, 24'hBFA39B, 24'hAF978B,
      24'hA3877B, 24'h977B6F, 24'h876F5F, 24'h7B6353,
      24'h6B5747, 24'h5F4B3B, 24'h533F33, 24'h433327,
      24'h372B1F, 24'h271F17, 24'h1B130F, 24'h0F0B07,
      24'h6F837B, 24'h677B6F, 24'h5F7367, 24'h576B5F,
      24'h4F6357, 24'h475B4F, 24'h3F5347, 24'h374B3F,
      24'h2F4337, 24'h2B3B2F, 24'h233327, 24'h1F2B1F,
      24'h172317, 24'h0F1B13, 24'h0B130B, 24'h070B07,
      24'hFFF31B, 24'hEFDF17, 24'hDBCB13, 24'hCBB70F,
      24'hBBA70F, 24'hAB970B, 24'h9B8307, 24'h8B7307,
      24'h7B6307, 24'h6B5300, 24'h5B4700, 24'h4B3700,
      24'h3B2B00, 24'h2B1F00, 24'h1B0F00, 24'h0B0700,
      24'h0000FF, 24'h0B0BEF, 24'h1313DF, 24'h1B1BCF,
      24'h2323BF, 24'h2B2BAF, 24'h2F2F9F, 24'h2F2F8F,
      24'h2F2F7F, 24'h2F2F6F, 24'h2F2F5F, 24'h2B2B4F,
      24'h23233F, 24'h1B1B2F, 24'h13131F, 24'h0B0B0F,
      24'h2B0000, 24'h3B0000, 24'h4B0700, 24'h5F0700,
      24'h6F0F00, 24'h7F1707, 24'h931F07, 24'hA3270B,
      24'hB7330F, 24'hC34B1B, 24'hCF632B, 24'hDB7F3B,
      24'hE3974F, 24'hE7AB5F, 24'hEFBF77, 24'hF7D38B,
      24'hA77B3B, 24'hB79B37, 24'hC7C337, 24'hE7E357,
      24'h7FBFFF, 24'hABE7FF, 24'hD7FFFF, 24'h670000,
      24'h8B0000, 24'hB30000, 24'hD70000, 24'hFF0000,
      24'hFFF393, 24'hFFF7C7, 24'hFFFFFF, 24'h9F5B53
   };

endpackage

`default_nettype wire

### rtl/npc_controller.sv
`default_nettype none

module npc_controller #(
   parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output npc_pkg::npc_cmd_type cmd,
   input  npc_pkg::npc_status_type status
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   // Last palette entry to read; counts above the ROM act as the full ROM
   localparam int SCAN_LIMIT =
      (PALETTE_ENTRIES > npc_pkg::ROM_SIZE) ? npc_pkg::ROM_SIZE : PALETTE_ENTRIES;
   localparam npc_pkg::index_type LAST_ADDR = npc_pkg::IDX_W'(SCAN_LIMIT - 1);

   logic [1:0]         state_ff, state_in;
   npc_pkg::index_type addr_ff, addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;
   logic               commit;

   // Output slot can take a new result this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign commit   = (state_ff == ST_DRAIN) && !status.pipe_busy && out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load   = req_valid && req_ready;
   assign cmd.issue  = (state_ff == ST_SCAN);
   assign cmd.addr   = addr_ff;
   assign cmd.commit = commit;

   // Sequence one search: read every entry, drain, then hand off
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      case (state_ff)
         ST_IDLE: begin
            addr_in = '0;
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result until the receiver takes the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A new search never starts while the previous one is still in flight
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !status.pipe_busy)
      else $error("load while pipeline busy");

   // The scan reads entries in order, one per cycle
   a_addr_step: assert property (@(posedge clock) disable iff (reset)
      cmd.issue && (addr_ff != LAST_ADDR) |=> cmd.issue && (addr_ff == $past(addr_ff) + 1'b1))
      else $error("scan address skipped");

   // A pending result is never overwritten before its transfer
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      commit |-> !rsp_valid_ff || rsp_ready)
      else $error("result overwritten");

endmodule

`default_nettype wire

### rtl/npc_datapath.sv
`default_nettype none

module npc_datapath (
   input  wire                     clock,
   input  wire                     reset,
   input  npc_pkg::npc_cmd_type    cmd,
   output npc_pkg::npc_status_type status,
   input  npc_pkg::color_type      req_red,
   input  npc_pkg::color_type      req_green,
   input  npc_pkg::color_type      req_blue,
   input  wire                     req_new_image,
   output npc_pkg::index_type      rsp_palette_index,
   output npc_pkg::dist_type       rsp_distance,
   output npc_pkg::dist_type       rsp_worst_distance_out,
   output npc_pkg::color_type      rsp_worst_red,
   output npc_pkg::color_type      rsp_worst_green,
   output npc_pkg::color_type      rsp_worst_blue,
   output npc_pkg::color_type      rsp_worst_match_red,
   output npc_pkg::color_type      rsp_worst_match_green,
   output npc_pkg::color_type      rsp_worst_match_blue
);

   localparam npc_pkg::index_type PRIO_BASE = npc_pkg::IDX_W'(npc_pkg::PRIORITY_BASE);

   // Source color
   npc_pkg::rgb_type   src_ff;

   // Stage 1: palette entry read
   logic               s1_vld_ff;
   npc_pkg::index_type s1_idx_ff;
   npc_pkg::rgb_type   s1_entry_ff;

   // Stage 2: squared distance
   logic               s2_vld_ff;
   npc_pkg::index_type s2_idx_ff;
   npc_pkg::rgb_type   s2_entry_ff;
   npc_pkg::dist_type  s2_dist_ff;

   // Running best and high priority exact match
   npc_pkg::index_type best_idx_ff;
   npc_pkg::dist_type  best_dist_ff;
   npc_pkg::rgb_type   best_color_ff;
   logic               prio_hit_ff;
   npc_pkg::index_type prio_idx_ff;

   // Worst-match record
   npc_pkg::dist_type  worst_dist_ff, worst_dist_in;
   npc_pkg::rgb_type   worst_src_ff, worst_src_in;
   npc_pkg::rgb_type   worst_match_ff, worst_match_in;
   logic               clear_pend_ff;

   // Output register
   npc_pkg::index_type out_idx_ff;
   npc_pkg::dist_type  out_dist_ff;

   npc_pkg::color_type dr, dg, db;
   logic [2*npc_pkg::COLOR_W-1:0] sq_r, sq_g, sq_b;
   npc_pkg::dist_type  dist_sum;
   npc_pkg::dist_type  record_base;
   logic               take_best;
   logic               take_prio;
   logic               update_record;
   logic               clear_record;

   assign status.pipe_busy = s1_vld_ff || s2_vld_ff;

   // Per-channel absolute difference and square
   always_comb begin
      dr   = (s1_entry_ff.red   > src_ff.red)   ? s1_entry_ff.red   - src_ff.red
                                                : src_ff.red   - s1_entry_ff.red;
      dg   = (s1_entry_ff.green > src_ff.green) ? s1_entry_ff.green - src_ff.green
                                                : src_ff.green - s1_entry_ff.green;
      db   = (s1_entry_ff.blue  > src_ff.blue)  ? s1_entry_ff.blue  - src_ff.blue
                                                : src_ff.blue  - s1_entry_ff.blue;
      sq_r = (2*npc_pkg::COLOR_W)'(dr) * (2*npc_pkg::COLOR_W)'(dr);
      sq_g = (2*npc_pkg::COLOR_W)'(dg) * (2*npc_pkg::COLOR_W)'(dg);
      sq_b = (2*npc_pkg::COLOR_W)'(db) * (2*npc_pkg::COLOR_W)'(db);
      dist_sum = npc_pkg::DIST_W'(sq_r) + npc_pkg::DIST_W'(sq_g) + npc_pkg::DIST_W'(sq_b);
   end

   // Entry zero seeds the search; later entries win only when strictly closer
   assign take_best = s2_vld_ff && ((s2_idx_ff == '0) || (s2_dist_ff < best_dist_ff));
   assign take_prio = s2_vld_ff && !prio_hit_ff && (s2_dist_ff == '0)
                      && (s2_idx_ff >= PRIO_BASE);

   // Record update at commit: a new image clears it first, so the pending
   // result keeps its record; a strictly worse match replaces it
   assign clear_record  = cmd.commit && clear_pend_ff;
   assign record_base   = clear_pend_ff ? '0 : worst_dist_ff;
   assign update_record = cmd.commit && !prio_hit_ff && (best_dist_ff > record_base);

   always_comb begin
      worst_dist_in  = worst_dist_ff;
      worst_src_in   = worst_src_ff;
      worst_match_in = worst_match_ff;
      if (update_record) begin
         worst_dist_in  = best_dist_ff;
         worst_src_in   = src_ff;
         worst_match_in = best_color_ff;
      end else if (clear_record) begin
         worst_dist_in  = '0;
         worst_src_in   = '0;
         worst_match_in = '0;
      end
   end

   // Control state of the pipeline and the record
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff      <= 1'b0;
         s2_vld_ff      <= 1'b0;
         prio_hit_ff    <= 1'b0;
         clear_pend_ff  <= 1'b0;
         worst_dist_ff  <= '0;
         worst_src_ff   <= '0;
         worst_match_ff <= '0;
      end else begin
         s1_vld_ff      <= cmd.issue;
         s2_vld_ff      <= s1_vld_ff;
         worst_dist_ff  <= worst_dist_in;
         worst_src_ff   <= worst_src_in;
         worst_match_ff <= worst_match_in;
         if (cmd.load) begin
            clear_pend_ff <= req_new_image;
         end
         if (cmd.load) begin
            prio_hit_ff <= 1'b0;
         end else if (take_prio) begin
            prio_hit_ff <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         src_ff <= '{red: req_red, green: req_green, blue: req_blue};
      end
      s1_idx_ff   <= cmd.addr;
      s1_entry_ff <= npc_pkg::PALETTE_ROM[cmd.addr];
      s2_idx_ff   <= s1_idx_ff;
      s2_entry_ff <= s1_entry_ff;
      s2_dist_ff  <= dist_sum;
      if (take_best) begin
         best_idx_ff   <= s2_idx_ff;
         best_dist_ff  <= s2_dist_ff;
         best_color_ff <= s2_entry_ff;
      end
      if (take_prio) begin
         prio_idx_ff <= s2_idx_ff;
      end
      if (cmd.commit) begin
         out_idx_ff  <= prio_hit_ff ? prio_idx_ff : best_idx_ff;
         out_dist_ff <= prio_hit_ff ? '0 : best_dist_ff;
      end
   end

   assign rsp_palette_index      = out_idx_ff;
   assign rsp_distance           = out_dist_ff;
   assign rsp_worst_distance_out = worst_dist_ff;
   assign rsp_worst_red          = worst_src_ff.red;
   assign rsp_worst_green        = worst_src_ff.green;
   assign rsp_worst_blue         = worst_src_ff.blue;
   assign rsp_worst_match_red    = worst_match_ff.red;
   assign rsp_worst_match_green  = worst_match_ff.green;
   assign rsp_worst_match_blue   = worst_match_ff.blue;

   // The answer is taken only once every entry has left the pipeline
   a_commit_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !s1_vld_ff && !s2_vld_ff)
      else $error("commit before pipeline drained");

   // The worst distance only grows unless a new image clears it
   a_worst_grows: assert property (@(posedge clock) disable iff (reset)
      !clear_record |=> worst_dist_ff >= $past(worst_dist_ff))
      else $error("worst distance shrank");

   // A priority hit always points into the high priority group
   a_prio_range: assert property (@(posedge clock) disable iff (reset)
      prio_hit_ff |-> prio_idx_ff >= PRIO_BASE)
      else $error("priority hit outside group");

endmodule

`default_nettype wire

### rtl/nearest_palette_color_unit.sv
`default_nettype none

// Nearest palette color unit.
// Input channel (req_*): one RGB888 color per transfer, plus req_new_image,
// which clears the worst-match record before that color is searched.
// Result channel (rsp_*): the chosen palette index, its squared distance and
// the worst-match record as it stands after this color.
// Each color scans palette entries 0 to PALETTE_ENTRIES-1, capped at the ROM
// size, through one shared distance pipeline, one entry per cycle. An exact
// match in entries 224 and up wins; otherwise the lowest index at the
// smallest distance wins. A color passes the scan, distance and compare
// stages and the output load before rsp_valid; the next color is taken only
// once the previous search has committed, so one search runs at a time,
// paced by the single palette ROM port feeding the distance unit.
// The search of the next color runs while a result waits in the output
// register; if the receiver stalls, the finished search holds until the
// pending result is transferred.
// Reset (synchronous, active high) clears the worst-match record to zero and
// empties the pipeline and the output register.
module nearest_palette_color_unit #(
   parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  npc_pkg::color_type req_red,
   input  npc_pkg::color_type req_green,
   input  npc_pkg::color_type req_blue,
   input  wire                req_new_image,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output npc_pkg::index_type rsp_palette_index,
   output npc_pkg::dist_type  rsp_distance,
   output npc_pkg::dist_type  rsp_worst_distance_out,
   output npc_pkg::color_type rsp_worst_red,
   output npc_pkg::color_type rsp_worst_green,
   output npc_pkg::color_type rsp_worst_blue,
   output npc_pkg::color_type rsp_worst_match_red,
   output npc_pkg::color_type rsp_worst_match_green,
   output npc_pkg::color_type rsp_worst_match_blue
);

   npc_pkg::npc_cmd_type    cmd;
   npc_pkg::npc_status_type status;

   npc_controller #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd),
      .status   (status)
   );

   npc_datapath u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_red               (req_red),
      .req_green             (req_green),
      .req_blue              (req_blue),
      .req_new_image         (req_new_image),
      .rsp_palette_index     (rsp_palette_index),
      .rsp_distance          (rsp_distance),
      .rsp_worst_distance_out(rsp_worst_distance_out),
      .rsp_worst_red         (rsp_worst_red),
      .rsp_worst_green       (rsp_worst_green),
      .rsp_worst_blue        (rsp_worst_blue),
      .rsp_worst_match_red   (rsp_worst_match_red),
      .rsp_worst_match_green (rsp_worst_match_green),
      .rsp_worst_match_blue  (rsp_worst_match_blue)
   );

endmodule

`default_nettype wire

### dv/tb_nearest_palette_color_unit.sv
module tb_nearest_palette_color_unit;

   localparam int NUM_ENTRIES  = 256;
   localparam int HOLD_CYCLES  = 3000;
   localparam int DRAIN_CYCLES = NUM_ENTRIES + 16;
   localparam int NO_MATCH     = 32'h7FFF_FFFF;
   localparam int MAX_REPORTS  = 10;

   // One color to quantize, optionally with typed expected index and distance
   typedef struct {
      npc_pkg::rgb_type   color;
      logic               clear;
      bit                 typed;
      npc_pkg::index_type pal_index;
      npc_pkg::dist_type  distance;
   } color_req_type;

   // Everything one result carries
   typedef struct {
      npc_pkg::index_type pal_index;
      npc_pkg::dist_type  distance;
      npc_pkg::dist_type  worst_distance;
      npc_pkg::rgb_type   worst_src;
      npc_pkg::rgb_type   worst_pal;
   } palette_match_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   npc_pkg::color_type req_red;
   npc_pkg::color_type req_green;
   npc_pkg::color_type req_blue;
   logic               req_new_image;
   logic               rsp_valid;
   logic               rsp_ready;
   npc_pkg::index_type rsp_palette_index;
   npc_pkg::dist_type  rsp_distance;
   npc_pkg::dist_type  rsp_worst_distance_out;
   npc_pkg::color_type rsp_worst_red;
   npc_pkg::color_type rsp_worst_green;
   npc_pkg::color_type rsp_worst_blue;
   npc_pkg::color_type rsp_worst_match_red;
   npc_pkg::color_type rsp_worst_match_green;
   npc_pkg::color_type rsp_worst_match_blue;

   // Worst-match record as the predictor sees it
   npc_pkg::dist_type rec_worst_distance = '0;
   npc_pkg::rgb_type  rec_worst_src      = '0;
   npc_pkg::rgb_type  rec_worst_pal      = '0;

   palette_match_type pending_matches[$];
   color_req_type     directed_colors[20];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  pressure_go   = 1'b0;
   logic hold_rsp;
   int  colors_sent   = 0;
   int  exact_hits    = 0;
   int  record_clears = 0;
   int  results_seen  = 0;
   int  mismatches    = 0;

   nearest_palette_color_unit #(
      .PALETTE_ENTRIES(NUM_ENTRIES)
   ) DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_red               (req_red),
      .req_green             (req_green),
      .req_blue              (req_blue),
      .req_new_image         (req_new_image),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_palette_index     (rsp_palette_index),
      .rsp_distance          (rsp_distance),
      .rsp_worst_distance_out(rsp_worst_distance_out),
      .rsp_worst_red         (rsp_worst_red),
      .rsp_worst_green       (rsp_worst_green),
      .rsp_worst_blue        (rsp_worst_blue),
      .rsp_worst_match_red   (rsp_worst_match_red),
      .rsp_worst_match_green (rsp_worst_match_green),
      .rsp_worst_match_blue  (rsp_worst_match_blue)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_nearest_palette_color_unit failed");
      $finish;
   end

   // Squared RGB distance between two colors
   function automatic int color_distance(npc_pkg::rgb_type a, npc_pkg::rgb_type b);
      int dr;
      int dg;
      int db;
      dr = int'(a.red) - int'(b.red);
      dg = int'(a.green) - int'(b.green);
      db = int'(a.blue) - int'(b.blue);
      return dr * dr + dg * dg + db * db;
   endfunction

   // Search the palette for one color and advance the worst-match record
   function automatic palette_match_type predict_match(npc_pkg::rgb_type c, logic clear);
      palette_match_type m;
      int                best_idx;
      int                best_d;
      int                d;
      bit                found;
      if (clear) begin
         rec_worst_distance = '0;
         rec_worst_src      = '0;
         rec_worst_pal      = '0;
      end
      found    = 1'b0;
      best_idx = 0;
      best_d   = NO_MATCH;
      // exact hit in the high priority group wins outright
      for (int i = npc_pkg::PRIORITY_BASE; i < NUM_ENTRIES; i++) begin
         if (!found && color_distance(c, npc_pkg::PALETTE_ROM[i]) == 0) begin
            found    = 1'b1;
            best_idx = i;
            best_d   = 0;
         end
      end
      if (!found) begin
         // lowest index at the smallest distance
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            d = color_distance(c, npc_pkg::PALETTE_ROM[i]);
            if (d < best_d) begin
               best_d   = d;
               best_idx = i;
            end
         end
         if (best_d > int'(rec_worst_distance)) begin
            rec_worst_distance = npc_pkg::dist_type'(best_d);
            rec_worst_src      = c;
            rec_worst_pal      = npc_pkg::PALETTE_ROM[best_idx];
         end
      end
      m.pal_index      = npc_pkg::index_type'(best_idx);
      m.distance       = npc_pkg::dist_type'(best_d);
      m.worst_distance = rec_worst_distance;
      m.worst_src      = rec_worst_src;
      m.worst_pal      = rec_worst_pal;
      return m;
   endfunction

   // Nudge one channel by a few steps, saturating at the ends
   function automatic npc_pkg::color_type jitter(npc_pkg::color_type v);
      int x;
      x = int'(v) + int'($urandom_range(8)) - 4;
      if (x < 0) x = 0;
      if (x > 255) x = 255;
      return npc_pkg::color_type'(x);
   endfunction

   // Mix of exact palette colors, near misses and arbitrary colors
   function automatic color_req_type random_color();
      color_req_type r;
      int            sel;
      int            idx;
      sel = $urandom_range(99);
      idx = ($urandom_range(1) == 1) ?
            $urandom_range(NUM_ENTRIES - 1, npc_pkg::PRIORITY_BASE) :
            $urandom_range(NUM_ENTRIES - 1);
      if (sel < 30) begin
         r.color = npc_pkg::PALETTE_ROM[idx];
      end else if (sel < 55) begin
         r.color.red   = jitter(npc_pkg::PALETTE_ROM[idx].red);
         r.color.green = jitter(npc_pkg::PALETTE_ROM[idx].green);
         r.color.blue  = jitter(npc_pkg::PALETTE_ROM[idx].blue);
      end else begin
         r.color = npc_pkg::rgb_type'($urandom);
      end
      r.clear     = ($urandom_range(19) == 0);
      r.typed     = 1'b0;
      r.pal_index = '0;
      r.distance  = '0;
      return r;
   endfunction

   // Offer one color and hold it until the transfer, then queue its result
   task automatic push_color(color_req_type r);
      palette_match_type m;
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_red       = r.color.red;
      req_green     = r.color.green;
      req_blue      = r.color.blue;
      req_new_image = r.clear;
      do @(posedge clock); while (!req_ready);
      m = predict_match(r.color, r.clear);
      if (r.typed) begin
         m.pal_index = r.pal_index;
         m.distance  = r.distance;
      end
      pending_matches.push_back(m);
      colors_sent++;
      if (m.distance == 0) exact_hits++;
      if (r.clear) record_clears++;
   endtask

   task automatic run_phase(int count, int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) push_color(random_color());
   endtask

   // Receiver: random stalls, or a long hold-off while pressure is on
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Count out the long receiver hold-off
   initial begin
      hold_rsp = 1'b0;
      wait (pressure_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Check each result transfer against the oldest expectation
   always @(posedge clock) begin : check_rsp
      palette_match_type got;
      palette_match_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.pal_index      = rsp_palette_index;
         got.distance       = rsp_distance;
         got.worst_distance = rsp_worst_distance_out;
         got.worst_src      = {rsp_worst_red, rsp_worst_green, rsp_worst_blue};
         got.worst_pal      = {rsp_worst_match_red, rsp_worst_match_green,
                               rsp_worst_match_blue};
         results_seen++;
         if (pending_matches.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: index %0d distance %0d",
                        got.pal_index, got.distance);
         end else begin
            want = pending_matches.pop_front();
            if (got.pal_index !== want.pal_index || got.distance !== want.distance ||
                got.worst_distance !== want.worst_distance ||
                got.worst_src !== want.worst_src || got.worst_pal !== want.worst_pal) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("result %0d expected: index %0d dist %0d worst %0d src %h pal %h",
                           results_seen, want.pal_index, want.distance,
                           want.worst_distance, want.worst_src, want.worst_pal);
                  $display("result %0d actual:   index %0d dist %0d worst %0d src %h pal %h",
                           results_seen, got.pal_index, got.distance,
                           got.worst_distance, got.worst_src, got.worst_pal);
               end
            end
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_red       = '0;
      req_green     = '0;
      req_blue      = '0;
      req_new_image = 1'b0;

      // color, clear, typed, expected index, expected distance
      directed_colors = '{
         '{24'h000000, 1'b0, 1'b1, 8'd0,   18'd0},  // black right after reset
         '{24'hFFFFFF, 1'b0, 1'b1, 8'd254, 18'd0},
         '{24'hFF0000, 1'b0, 1'b1, 8'd251, 18'd0},
         '{24'hFFF31B, 1'b0, 1'b1, 8'd111, 18'd0},  // lower of two equal entries
         '{24'h0000FF, 1'b0, 1'b1, 8'd208, 18'd0},
         '{24'h9F5B53, 1'b0, 1'b1, 8'd255, 18'd0},
         '{24'hEFDF17, 1'b0, 1'b1, 8'd193, 18'd0},
         '{24'h000001, 1'b0, 1'b1, 8'd0,   18'd1},  // first record entry
         '{24'h000100, 1'b0, 1'b1, 8'd0,   18'd1},  // tie keeps the earlier record
         '{24'h010000, 1'b0, 1'b1, 8'd0,   18'd1},
         '{24'h00FF00, 1'b0, 1'b0, 8'd0,   18'd0},
         '{24'hFF00FF, 1'b0, 1'b0, 8'd0,   18'd0},
         '{24'h00FFFF, 1'b0, 1'b0, 8'd0,   18'd0},
         '{24'hFFFF00, 1'b0, 1'b0, 8'd0,   18'd0},
         '{24'h808080, 1'b1, 1'b0, 8'd0,   18'd0},  // clear, then this color records
         '{24'h7F7F7F, 1'b0, 1'b0, 8'd0,   18'd0},
         '{24'hD7FFFF, 1'b1, 1'b1, 8'd246, 18'd0},  // clear with exact hit
         '{24'h123456, 1'b0, 1'b0, 8'd0,   18'd0},
         '{24'hFEDCBA, 1'b0, 1'b0, 8'd0,   18'd0},
         '{24'h000000, 1'b1, 1'b1, 8'd0,   18'd0}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed colors
      foreach (directed_colors[i]) push_color(directed_colors[i]);

      // random colors under each idling pattern
      run_phase(380, 0, 0);
      run_phase(380, 82, 0);
      run_phase(380, 0, 82);
      run_phase(380, 23, 23);

      // back the block up behind a long receiver hold-off
      send_idle_pct = 0;
      recv_idle_pct = 0;
      pressure_go   = 1'b1;
      repeat (30) push_color(random_color());

      @(negedge clock);
      req_valid = 1'b0;

      // drain and watch for stray results
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d colors: %0d exact palette hits, %0d record clears,",
               colors_sent, exact_hits, record_clears);
      $display("four idling patterns and a %0d-cycle receiver hold-off; %0d mismatches",
               HOLD_CYCLES, mismatches);
      if (mismatches == 0) begin
         $display("tb_nearest_palette_color_unit passed");
      end else begin
         $display("tb_nearest_palette_color_unit failed");
      end
      $finish;
   end

endmodule
